// ===== rtl/fpte_pkg.sv =====
// Shared constants, types and helpers for the FAT12 packed table engine.
package fpte_pkg;

  // Table geometry: two 12-bit entries share one 24-bit word (three bytes).
  localparam int ENTRIES  = 4096;
  localparam int WORDS    = (ENTRIES + 1) / 2;
  localparam int WADDR_W  = $clog2(WORDS);
  localparam int IDX_W    = $clog2(ENTRIES + 1);
  localparam int ENTRY_W  = 12;
  localparam int WORD_W   = 2 * ENTRY_W;
  localparam int CLUSTER_W = 12;
  localparam int LIMIT_W  = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2880;
  localparam logic [ENTRY_W-1:0] EOC_LOW     = 12'hFF8;
  localparam logic [ENTRY_W-1:0] BAD_MARK    = 12'hFF7;
  localparam logic [IDX_W-1:0]   FIRST_DATA  = IDX_W'(2);

  // Stream word widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // Result word bit positions, lowest field first.
  localparam int OUT_EOC_BIT   = 12;
  localparam int OUT_BAD_BIT   = 13;
  localparam int OUT_FOUND_BIT = 14;
  localparam int OUT_FREE_LSB  = 15;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FIND  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_HOLD
  } state_t;

  // Request from the controller to the table memory.
  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic [WADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] free_cluster;
    logic                 free_found;
    logic                 bad_cluster;
    logic                 end_of_chain;
    logic [ENTRY_W-1:0]   entry_value;
  } result_t;

  // Packs a result into the output word, zero filled to whole bytes.
  function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
    logic [OUT_DATA_W-1:0] w;
    w = '0;
    w[ENTRY_W-1:0]                          = r.entry_value;
    w[OUT_EOC_BIT]                          = r.end_of_chain;
    w[OUT_BAD_BIT]                          = r.bad_cluster;
    w[OUT_FOUND_BIT]                        = r.free_found;
    w[OUT_FREE_LSB +: CLUSTER_W]            = r.free_cluster;
    return w;
  endfunction

endpackage

// ===== rtl/fpte_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module fpte_ram #(
  parameter int DEPTH  = 2048,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fpte_ctrl.sv =====
// Sequencer for table clearing, entry read/write and the free-entry search.
module fpte_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [fpte_pkg::LIMIT_W-1:0]     search_limit,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fpte_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [fpte_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fpte_pkg::OUT_DATA_W-1:0]  m_tdata,
  output fpte_pkg::ram_req_t               ram_req,
  input  logic [fpte_pkg::WORD_W-1:0]      ram_rdata
);

  fpte_pkg::state_t state, state_next;

  logic [fpte_pkg::WADDR_W-1:0]   clr_addr;
  logic [fpte_pkg::IN_USER_W-1:0] cur_kind;
  logic [fpte_pkg::CLUSTER_W-1:0] cur_cluster;
  logic [fpte_pkg::ENTRY_W-1:0]   cur_value;
  logic [fpte_pkg::IDX_W-1:0]     idx, idx_next;
  fpte_pkg::result_t              hold_res;

  logic [fpte_pkg::CLUSTER_W-1:0] in_cluster;
  logic [fpte_pkg::ENTRY_W-1:0]   in_value;
  logic [fpte_pkg::IDX_W-1:0]     in_start;
  logic [fpte_pkg::IDX_W-1:0]     bound;
  logic                           accept;
  logic                           out_free;
  logic                           clr_last;
  logic                           cur_in_range;
  logic [fpte_pkg::ENTRY_W-1:0]   cur_entry;
  logic [fpte_pkg::IDX_W-1:0]     hi_idx;
  logic                           lo_hit, hi_hit, search_end;
  logic                           done;
  fpte_pkg::result_t              res;

  assign in_cluster = s_tdata[fpte_pkg::CLUSTER_W-1:0];
  assign in_value   = s_tdata[fpte_pkg::CLUSTER_W +: fpte_pkg::ENTRY_W];
  assign in_start   = (fpte_pkg::IDX_W'(in_cluster) < fpte_pkg::FIRST_DATA) ?
                      fpte_pkg::FIRST_DATA : fpte_pkg::IDX_W'(in_cluster);
  assign bound      = (search_limit > fpte_pkg::LIMIT_W'(fpte_pkg::ENTRIES)) ?
                      fpte_pkg::IDX_W'(fpte_pkg::ENTRIES) : fpte_pkg::IDX_W'(search_limit);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign clr_last   = (clr_addr == fpte_pkg::WADDR_W'(fpte_pkg::WORDS - 1));

  // Entry of the current cluster out of its word.
  assign cur_in_range = ({1'b0, cur_cluster} < (fpte_pkg::CLUSTER_W+1)'(fpte_pkg::ENTRIES));
  assign cur_entry    = cur_cluster[0] ? ram_rdata[fpte_pkg::ENTRY_W +: fpte_pkg::ENTRY_W]
                                       : ram_rdata[fpte_pkg::ENTRY_W-1:0];

  // Search checks both entries of the word at once, the low one only when the index is even.
  assign hi_idx     = idx | fpte_pkg::IDX_W'(1);
  assign search_end = (idx >= bound);
  assign lo_hit     = !idx[0] && (ram_rdata[fpte_pkg::ENTRY_W-1:0] == '0);
  assign hi_hit     = (hi_idx < bound) &&
                      (ram_rdata[fpte_pkg::ENTRY_W +: fpte_pkg::ENTRY_W] == '0);
  assign idx_next   = hi_idx + fpte_pkg::IDX_W'(1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      fpte_pkg::ST_CLEAR: begin
        if (clr_last) state_next = fpte_pkg::ST_IDLE;
      end
      fpte_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == fpte_pkg::KIND_FIND) ? fpte_pkg::ST_SEARCH
                                                        : fpte_pkg::ST_EXEC;
        end
      end
      fpte_pkg::ST_EXEC, fpte_pkg::ST_SEARCH, fpte_pkg::ST_HOLD: begin
        if (done) state_next = out_free ? fpte_pkg::ST_IDLE : fpte_pkg::ST_HOLD;
      end
      default: state_next = fpte_pkg::ST_CLEAR;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    s_tready      = 1'b0;
    done          = 1'b0;
    res           = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = fpte_pkg::WADDR_W'(cur_cluster >> 1);
    ram_req.wdata = ram_rdata;
    ram_req.raddr = fpte_pkg::WADDR_W'(cur_cluster >> 1);
    unique case (state)
      fpte_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = '0;
      end
      fpte_pkg::ST_IDLE: begin
        s_tready      = 1'b1;
        ram_req.raddr = (s_tuser == fpte_pkg::KIND_FIND) ?
                        fpte_pkg::WADDR_W'(in_start >> 1) :
                        fpte_pkg::WADDR_W'(in_cluster >> 1);
      end
      fpte_pkg::ST_EXEC: begin
        done = 1'b1;
        if (cur_kind == fpte_pkg::KIND_READ && cur_in_range) begin
          res.entry_value  = cur_entry;
          res.end_of_chain = (cur_entry >= fpte_pkg::EOC_LOW);
          res.bad_cluster  = (cur_entry == fpte_pkg::BAD_MARK);
        end
        // Write merges the new entry with its neighbor in the same word.
        if (cur_kind == fpte_pkg::KIND_WRITE && cur_in_range) begin
          ram_req.we = 1'b1;
          if (cur_cluster[0]) begin
            ram_req.wdata = {cur_value, ram_rdata[fpte_pkg::ENTRY_W-1:0]};
          end else begin
            ram_req.wdata = {ram_rdata[fpte_pkg::ENTRY_W +: fpte_pkg::ENTRY_W], cur_value};
          end
        end
      end
      fpte_pkg::ST_SEARCH: begin
        ram_req.raddr = fpte_pkg::WADDR_W'(idx_next >> 1);
        priority if (search_end) begin
          done = 1'b1;
        end else if (lo_hit) begin
          done             = 1'b1;
          res.free_found   = 1'b1;
          res.free_cluster = fpte_pkg::CLUSTER_W'(idx);
        end else if (hi_hit) begin
          done             = 1'b1;
          res.free_found   = 1'b1;
          res.free_cluster = fpte_pkg::CLUSTER_W'(hi_idx);
        end else begin
          done = 1'b0;
        end
      end
      fpte_pkg::ST_HOLD: begin
        done = 1'b1;
        res  = hold_res;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fpte_pkg::ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fpte_pkg::ST_CLEAR) clr_addr <= clr_addr + fpte_pkg::WADDR_W'(1);
      if (done && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind    <= s_tuser;
      cur_cluster <= in_cluster;
      cur_value   <= in_value;
      idx         <= in_start;
    end else if (state == fpte_pkg::ST_SEARCH) begin
      idx <= idx_next;
    end
    if (done && out_free) m_tdata <= fpte_pkg::pack_result(res);
    if (done && !out_free) hold_res <= res;
  end

  // The table is never written while waiting for a new word.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == fpte_pkg::ST_IDLE |-> !ram_req.we)
    else $error("table write while idle");

  // An accepted word always starts an operation.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == fpte_pkg::ST_EXEC || state == fpte_pkg::ST_SEARCH))
    else $error("accepted word did not start an operation");

  // A found free cluster is never a reserved one and lies below the bound.
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    state == fpte_pkg::ST_SEARCH && done && res.free_found |->
      fpte_pkg::IDX_W'(res.free_cluster) >= fpte_pkg::FIRST_DATA &&
      fpte_pkg::IDX_W'(res.free_cluster) < bound)
    else $error("free cluster out of range");

  // End-of-chain and bad-cluster marks exclude each other.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[fpte_pkg::OUT_EOC_BIT] && m_tdata[fpte_pkg::OUT_BAD_BIT]))
    else $error("both entry flags set");

  // No result is produced while the table is being cleared.
  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    state == fpte_pkg::ST_CLEAR |-> !done)
    else $error("result during clearing");

endmodule

// ===== rtl/fat12_packed_table_engine_unit.sv =====
// FAT12 allocation table engine: top level with the search limit register.
// With the output free, the execute state of an accepted read or write sets m_tvalid.
// No new read or write is taken until the last is done; the table RAM is read before use.
// Find free checks two entries per cycle (one RAM word); its result follows the word that
//   holds the free entry, or a final search step when the search runs out at the bound.
// Reset: synchronous; afterwards a clearing pass zeroes every word of the table RAM
//   one word a cycle, s_tready stays low meanwhile; search_limit resets to 2880.
module fat12_packed_table_engine_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpte_pkg::LIMIT_W-1:0]    cfg_wdata,  // search_limit
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fpte_pkg::IN_DATA_W-1:0]  s_tdata,    // cluster[11:0], value[23:12]
  input  logic [fpte_pkg::IN_USER_W-1:0]  s_tuser,    // kind[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fpte_pkg::OUT_DATA_W-1:0] m_tdata     // entry_value[11:0], end_of_chain[12],
                                                      // bad_cluster[13], free_found[14],
                                                      // free_cluster[26:15], zero[31:27]
);

  logic [fpte_pkg::LIMIT_W-1:0] search_limit;
  fpte_pkg::ram_req_t           ram_req;
  logic [fpte_pkg::WORD_W-1:0]  ram_rdata;

  // Search limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= fpte_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      search_limit <= cfg_wdata;
    end
  end

  fpte_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .search_limit (search_limit),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  // Packed table: word n holds cluster 2n in the low half and 2n+1 in the high half.
  fpte_ram #(
    .DEPTH  (fpte_pkg::WORDS),
    .WIDTH  (fpte_pkg::WORD_W),
    .ADDR_W (fpte_pkg::WADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
